>>> hw/rtl/p3rs_pkg.sv
package p3rs_pkg;

  // Width of the shared divider's step counter (covers every supported width).
  localparam int DIV_CNT_W = 5;

  // Configuration register indexes.
  localparam logic [1:0] REG_CAM_HEIGHT  = 2'd0;
  localparam logic [1:0] REG_HORIZON_ROW = 2'd1;
  localparam logic [1:0] REG_ROAD_WIDTH  = 2'd2;
  localparam logic [1:0] REG_ROAD_CENTER = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_GROUND = 3'd0;
  localparam logic [2:0] KIND_ROAD   = 3'd1;
  localparam logic [2:0] KIND_CENTRE = 3'd2;
  localparam logic [2:0] KIND_SIDE   = 3'd3;
  localparam logic [2:0] KIND_SPRITE = 3'd4;

  // Colours.
  localparam logic [2:0] COL_GROUND_LIGHT = 3'd0;
  localparam logic [2:0] COL_GROUND_DARK  = 3'd1;
  localparam logic [2:0] COL_ROAD_LIGHT   = 3'd2;
  localparam logic [2:0] COL_ROAD_DARK    = 3'd3;
  localparam logic [2:0] COL_WHITE        = 3'd4;
  localparam logic [2:0] COL_RED          = 3'd5;
  localparam logic [2:0] COL_NONE         = 3'd6;

  // Item slots of one row, in emission order.
  localparam logic [2:0] IT_GROUND   = 3'd0;
  localparam logic [2:0] IT_ROAD     = 3'd1;
  localparam logic [2:0] IT_CENTRE_L = 3'd2;
  localparam logic [2:0] IT_CENTRE_R = 3'd3;
  localparam logic [2:0] IT_SIDE_L   = 3'd4;
  localparam logic [2:0] IT_SIDE_R   = 3'd5;
  localparam logic [2:0] IT_SPRITE_L = 3'd6;
  localparam logic [2:0] IT_SPRITE_R = 3'd7;

  // Request to the shared divider.
  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] count;
  } div_ctl_t;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Everything the output stage needs to form the items of one row.
  typedef struct packed {
    logic [12:0] c;
    logic [11:0] hw;
    logic [11:0] w3;
    logic [11:0] o20;
    logic [11:0] w15;
    logic [11:0] p16;
    logic [7:0]  row;
    logic [15:0] scale;
    logic        half_odd;
    logic        sev_odd;
  } span_ctx_t;

endpackage

>>> hw/rtl/p3rs_div.sv
module p3rs_div #(
  parameter int QW = 21
) (
  input  logic                clk,
  input  logic                rst,
  input  p3rs_pkg::div_ctl_t  ctl,
  input  logic [15:0]         r_init,
  input  logic [QW-1:0]       dividend,
  input  logic [15:0]         divisor,
  output p3rs_pkg::div_stat_t stat,
  output logic [QW-1:0]       quotient
);
  import p3rs_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [15:0]          rem;
  logic [QW-1:0]        dvd;
  logic [15:0]          dsr;
  logic [QW-1:0]        q;

  logic [16:0] sh;
  logic [16:0] diff;
  logic        ge;
  logic [15:0] rem_next;

  // One restoring step: bring in the next dividend bit and try a subtract.
  always_comb begin
    sh       = {rem, dvd[QW-1]};
    diff     = sh - {1'b0, dsr};
    ge       = sh >= {1'b0, dsr};
    rem_next = ge ? diff[15:0] : sh[15:0];
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.count;
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Remainder, dividend shifter and quotient.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= r_init;
      dvd <= dividend;
      dsr <= divisor;
      q   <= '0;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= dvd << 1;
      q   <= {q[QW-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = q;

endmodule

>>> hw/rtl/p3rs_emit.sv
module p3rs_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [2:0]          idx,
  input  logic                item_last,
  input  p3rs_pkg::span_ctx_t ctx,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          kind,
  output logic [2:0]          color,
  output logic signed [15:0]  x_start,
  output logic signed [15:0]  x_end,
  output logic signed [15:0]  y_pos,
  output logic [15:0]         scale,
  output logic                last
);
  import p3rs_pkg::*;

  logic signed [15:0] cs, hws, w3s, o20s, w15s, p16s, ys;
  logic signed [15:0] ls_c, ls_s, rs_s, lx, rx;
  logic [2:0]         kind_d, color_d;
  logic signed [15:0] xs_d, xe_d, y_d;

  // All positions stay well inside the 16-bit signed range, so no clamp is needed.
  always_comb begin
    cs   = $signed({3'b000, ctx.c});
    hws  = $signed({4'b0000, ctx.hw});
    w3s  = $signed({4'b0000, ctx.w3});
    o20s = $signed({4'b0000, ctx.o20});
    w15s = $signed({4'b0000, ctx.w15});
    p16s = $signed({4'b0000, ctx.p16});
    ys   = $signed({4'b0000, ctx.row, 4'b0000});
    ls_c = cs - w3s - o20s;
    ls_s = cs - hws;
    rs_s = cs + hws - w15s;
    lx   = cs - hws - p16s;
    rx   = cs + hws + p16s;
  end

  // Item decode for the current slot.
  always_comb begin
    kind_d  = KIND_GROUND;
    color_d = COL_NONE;
    xs_d    = '0;
    xe_d    = '0;
    y_d     = ys;
    unique case (idx)
      IT_GROUND: begin
        kind_d  = KIND_GROUND;
        color_d = ctx.half_odd ? COL_GROUND_LIGHT : COL_GROUND_DARK;
        xs_d    = '0;
        xe_d    = cs + cs;
      end
      IT_ROAD: begin
        kind_d  = KIND_ROAD;
        color_d = ctx.half_odd ? COL_ROAD_LIGHT : COL_ROAD_DARK;
        xs_d    = cs - hws;
        xe_d    = cs + hws;
      end
      IT_CENTRE_L: begin
        kind_d  = KIND_CENTRE;
        color_d = COL_WHITE;
        xs_d    = ls_c;
        xe_d    = ls_c + w3s;
      end
      IT_CENTRE_R: begin
        kind_d  = KIND_CENTRE;
        color_d = COL_WHITE;
        xs_d    = cs + o20s;
        xe_d    = cs + o20s + w3s;
      end
      IT_SIDE_L: begin
        kind_d  = KIND_SIDE;
        color_d = ctx.sev_odd ? COL_WHITE : COL_RED;
        xs_d    = ls_s;
        xe_d    = ls_s + w15s;
      end
      IT_SIDE_R: begin
        kind_d  = KIND_SIDE;
        color_d = ctx.sev_odd ? COL_WHITE : COL_RED;
        xs_d    = rs_s;
        xe_d    = rs_s + w15s;
      end
      IT_SPRITE_L: begin
        kind_d  = KIND_SPRITE;
        color_d = COL_NONE;
        xs_d    = lx;
        xe_d    = lx;
        y_d     = ys - p16s;
      end
      IT_SPRITE_R: begin
        kind_d  = KIND_SPRITE;
        color_d = COL_NONE;
        xs_d    = rx;
        xe_d    = rx;
        y_d     = ys - p16s;
      end
    endcase
  end

  assign can_load = !out_valid || out_ready;

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      kind    <= kind_d;
      color   <= color_d;
      x_start <= xs_d;
      x_end   <= xe_d;
      y_pos   <= y_d;
      scale   <= ctx.scale;
      last    <= item_last;
    end
  end

  a_sprite_point: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_SPRITE) |-> (x_start == x_end))
    else $error("sprite anchor with differing start and end");

  a_ground_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_GROUND) |-> !last)
    else $error("ground span marked as final item of a row");

endmodule

>>> hw/rtl/pseudo3d_road_scanline_spans_unit.sv
// Row at or above the horizon: accepted and dropped, no items.
// Row below the horizon: a depth pass and a scale pass on the divider, the scale pass skipped
// when the rows below the horizon reach the camera height; then one item per cycle while the
// output is taken, n = 4..8 items; no new row is accepted until its last item is loaded.
// Both passes are 16-step passes of the shared one-bit-per-cycle divider.
// Synchronous active-high reset restores the register defaults and clears control state.
module pseudo3d_road_scanline_spans_unit #(
  parameter int Z_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         row,
  input  logic [23:0]        cam_z,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         kind,
  output logic [2:0]         color,
  output logic signed [15:0] x_start,
  output logic signed [15:0] x_end,
  output logic signed [15:0] y_pos,
  output logic [15:0]        scale,
  output logic               last
);
  import p3rs_pkg::*;

  localparam int WW   = ((24 > 8 + Z_FRAC_BITS) ? 24 : 8 + Z_FRAC_BITS) + 1;
  localparam int DZ_W = 16 + Z_FRAC_BITS;
  localparam int XW   = WW + 4 - Z_FRAC_BITS;
  localparam int QW   = 16;

  // Reciprocal of seven scaled by 2^(XW+3); exact for every value below 2^XW.
  localparam logic [XW:0] SEV_RECIP = (XW + 1)'(((64'd1 << (XW + 3)) + 64'd6) / 64'd7);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DEPTH    = 3'd1;
  localparam logic [2:0] S_WORLD    = 3'd2;
  localparam logic [2:0] S_SEVSTART = 3'd3;
  localparam logic [2:0] S_SEV      = 3'd4;
  localparam logic [2:0] S_SCALE    = 3'd5;
  localparam logic [2:0] S_LEN      = 3'd6;
  localparam logic [2:0] S_EMIT     = 3'd7;

  // Saturate a length to Q8.8 and drop to Q8.4.
  function automatic logic [11:0] sat_len(input logic [25:0] v);
    return (v > 26'd65535) ? 12'hFFF : v[15:4];
  endfunction

  logic [15:0] cam_height;
  logic [7:0]  horizon_row;
  logic [9:0]  road_width;
  logic [8:0]  road_center;

  logic [2:0]  state;
  logic [2:0]  idx;
  logic [15:0] last_segment;

  logic [7:0]    row_r;
  logic [23:0]   camz_r;
  logic [7:0]    d_r;
  logic [15:0]   depth_r;
  logic [WW-1:0] world_r;
  logic [XW-1:0] x_r;
  logic          half_r;
  logic          sev_r;
  logic          spr_r;
  logic [15:0]   scale_r;
  logic [11:0]   hw_r, w3_r, o20_r, w15_r, p16_r;

  logic [15:0]     ch;
  logic [7:0]      d_in;
  logic            accept;
  logic            below;
  logic [DZ_W-1:0] dz;
  logic [WW+3:0]   wx10;
  logic [XW-1:0]   x_val;
  logic [2*XW:0]   sev_prod;
  logic [15:0]     seg;
  logic [25:0]     prod_rw;

  div_ctl_t      div_ctl;
  div_stat_t     div_stat;
  logic [15:0]   div_rinit;
  logic [QW-1:0] div_dividend;
  logic [15:0]   div_divisor;
  logic [QW-1:0] div_q;

  span_ctx_t ctx;
  logic      can_load;
  logic      emit_load;
  logic      item_last;
  logic [2:0] idx_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_height  <= 16'd6400;
      horizon_row <= 8'd144;
      road_width  <= 10'd250;
      road_center <= 9'd160;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAM_HEIGHT:  cam_height  <= cfg_data;
        REG_HORIZON_ROW: horizon_row <= cfg_data[7:0];
        REG_ROAD_WIDTH:  road_width  <= cfg_data[9:0];
        REG_ROAD_CENTER: road_center <= cfg_data[8:0];
      endcase
    end
  end

  // Derived values used by the sequencer.
  always_comb begin
    ch       = (cam_height == 16'd0) ? 16'd1 : cam_height;
    d_in     = row - horizon_row;
    in_ready = (state == S_IDLE);
    accept   = in_valid && in_ready;
    below    = row > horizon_row;
    dz       = DZ_W'(depth_r) << Z_FRAC_BITS;
    wx10     = ((WW + 4)'(world_r) << 3) + ((WW + 4)'(world_r) << 1);
    x_val    = XW'(wx10 >> Z_FRAC_BITS);
    sev_prod = (2 * XW + 1)'(x_r) * (2 * XW + 1)'(SEV_RECIP);
    seg      = 16'(world_r >> (Z_FRAC_BITS + 1));
    prod_rw  = 26'(road_width) * 26'(scale_r);
  end

  // Requests to the shared divider.
  always_comb begin
    div_ctl      = '0;
    div_rinit    = '0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && below) begin
          div_ctl.start = 1'b1;
          div_ctl.count = DIV_CNT_W'(16);
          div_dividend  = ch;
          div_divisor   = {8'b0, d_in};
        end
      end
      S_SEV: begin
        // Scale is d * 65536 / height; d starts in the remainder, so only the
        // sixteen fraction steps run.
        if ({8'b0, d_r} < ch) begin
          div_ctl.start = 1'b1;
          div_ctl.count = DIV_CNT_W'(16);
          div_rinit     = {8'b0, d_r};
          div_divisor   = ch;
        end
      end
      default: ;
    endcase
  end

  p3rs_div #(.QW(QW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .r_init   (div_rinit),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Slot sequencing: centre stripes only on odd half-metre, anchors on a new segment.
  always_comb begin
    item_last = (idx == IT_SPRITE_R) || ((idx == IT_SIDE_R) && !spr_r);
    emit_load = (state == S_EMIT) && can_load;
    if (idx == IT_ROAD) begin
      idx_next = half_r ? IT_CENTRE_L : IT_SIDE_L;
    end else begin
      idx_next = idx + 3'd1;
    end
  end

  // Sequencer and remembered segment.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= IT_GROUND;
      last_segment <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (frame_start) begin
              last_segment <= '0;
            end
            if (below) begin
              state <= S_DEPTH;
            end
          end
        end
        S_DEPTH: begin
          if (div_stat.done) begin
            state <= S_WORLD;
          end
        end
        S_WORLD: state <= S_SEVSTART;
        S_SEVSTART: begin
          last_segment <= seg;
          state        <= S_SEV;
        end
        S_SEV: begin
          state <= ({8'b0, d_r} < ch) ? S_SCALE : S_LEN;
        end
        S_SCALE: begin
          if (div_stat.done) begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          idx   <= IT_GROUND;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (can_load) begin
            if (item_last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx_next;
            end
          end
        end
      endcase
    end
  end

  // Row datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r  <= row;
      camz_r <= cam_z;
      d_r    <= d_in;
    end
    if (state == S_DEPTH && div_stat.done) begin
      depth_r <= div_q[15:0];
    end
    if (state == S_WORLD) begin
      world_r <= WW'(camz_r) + WW'(dz >> 8);
    end
    if (state == S_SEVSTART) begin
      half_r <= world_r[Z_FRAC_BITS-1];
      spr_r  <= seg != last_segment;
      x_r    <= x_val;
    end
    // The quotient by seven starts at bit XW+3 of the product; its lowest bit is the parity.
    if (state == S_SEV) begin
      sev_r <= sev_prod[XW+3];
      if (!({8'b0, d_r} < ch)) begin
        scale_r <= 16'hFFFF;
      end
    end
    if (state == S_SCALE && div_stat.done) begin
      scale_r <= div_q[15:0];
    end
    if (state == S_LEN) begin
      hw_r  <= sat_len(prod_rw >> 1);
      w3_r  <= sat_len(26'(scale_r) * 26'd3);
      o20_r <= sat_len(26'(scale_r) * 26'd20);
      w15_r <= sat_len(26'(scale_r) * 26'd15);
      p16_r <= sat_len(26'(scale_r) << 4);
    end
  end

  always_comb begin
    ctx.c        = {road_center, 4'b0000};
    ctx.hw       = hw_r;
    ctx.w3       = w3_r;
    ctx.o20      = o20_r;
    ctx.w15      = w15_r;
    ctx.p16      = p16_r;
    ctx.row      = row_r;
    ctx.scale    = scale_r;
    ctx.half_odd = half_r;
    ctx.sev_odd  = sev_r;
  end

  p3rs_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (emit_load),
    .idx       (idx),
    .item_last (item_last),
    .ctx       (ctx),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .color     (color),
    .x_start   (x_start),
    .x_end     (x_end),
    .y_pos     (y_pos),
    .scale     (scale),
    .last      (last)
  );

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DEPTH || state == S_SCALE))
    else $error("divider finished outside a waiting state");

  a_idle_div_free: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_stat.busy)
    else $error("block ready while the divider is still busy");

endmodule
